>>> hw/rtl/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared types and constants for the life generation row stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package lgrs_pkg;

  localparam int ROW_BITS   = 64;
  localparam int WIDTH_W    = 7;
  localparam int LANE_COLS  = 8;
  localparam int NUM_LANES  = ROW_BITS / LANE_COLS;
  localparam int CNT_W      = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_WIDTH = 1'b0;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 7'd64;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_cells;
    logic                last_row;
  } in_item_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] next_cells;
    logic                is_last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/lgrs_lane.sv
// ----------------------------------------------------------------------------
// lgrs_lane
// One lane of the B3/S23 rule: next states for a slice of columns.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_lane
  import lgrs_pkg::*;
(
  input  wire logic [LANE_COLS+1:0] up,
  input  wire logic [LANE_COLS+1:0] mid,
  input  wire logic [LANE_COLS+1:0] down,
  output logic      [LANE_COLS-1:0] next_cells
);

  // slice bit 0 and LANE_COLS+1 are halo columns from the neighbor lanes
  always_comb begin
    logic [CNT_W-1:0] n;
    for (int c = 0; c < LANE_COLS; c++) begin
      n = CNT_W'(up[c]) + CNT_W'(up[c+1]) + CNT_W'(up[c+2])
        + CNT_W'(mid[c]) + CNT_W'(mid[c+2])
        + CNT_W'(down[c]) + CNT_W'(down[c+1]) + CNT_W'(down[c+2]);
      next_cells[c] = (n == CNT_W'(3)) || ((n == CNT_W'(2)) && mid[c+1]);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lgrs_out_fifo.sv
// ----------------------------------------------------------------------------
// lgrs_out_fifo
// Two-entry result buffer between the lanes and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_out_fifo
  import lgrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  out_item_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

>>> hw/rtl/life_generation_row_stepper.sv
// ----------------------------------------------------------------------------
// life_generation_row_stepper
// One generation of B3/S23 Life over a bounded grid, one row per transfer.
// ----------------------------------------------------------------------------
// Rows enter top to bottom, one per cycle while the buffer has room, and each
// row after the first produces the next state of the row above it; the bottom
// row (last_row set) also produces its own next state with is_last set,
// computed from the registered flush flag by the same lane array while the
// input stalls. Eight lanes of eight columns evaluate one full row per cycle;
// a two-entry output buffer lets a new row enter while a result waits. Columns
// at or above row_width (clamped to MAX_COLS) are dead and read back as zero.
`default_nettype none

module life_generation_row_stepper
  import lgrs_pkg::*;
#(
  parameter int MAX_COLS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [WIDTH_W-1:0]  row_width_r;
  logic [WIDTH_W-1:0]  width_eff;
  logic [ROW_BITS-1:0] mask;
  logic [ROW_BITS-1:0] row_above_r;
  logic [ROW_BITS-1:0] row_held_r;
  logic                row_pending_r;
  logic                flush_r;
  logic [ROW_BITS-1:0] cur_m;
  logic [ROW_BITS+1:0] up_pad;
  logic [ROW_BITS+1:0] mid_pad;
  logic [ROW_BITS+1:0] down_pad;
  logic [ROW_BITS-1:0] lane_out;
  logic                in_fire;
  logic                flush_go;
  logic                fifo_full;
  logic                push;
  out_item_t           push_item;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ROW_WIDTH)) begin
      row_width_r <= pwdata[WIDTH_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROW_WIDTH) ?
                  {{(APB_DATA_W-WIDTH_W){1'b0}}, row_width_r} : '0;

  // column mask
  assign width_eff = (row_width_r > WIDTH_W'(MAX_COLS)) ? WIDTH_W'(MAX_COLS) : row_width_r;

  for (genvar c = 0; c < ROW_BITS; c++) begin : g_mask
    assign mask[c] = (WIDTH_W'(c) < width_eff);
  end

  assign cur_m = in_data.row_cells & mask;

  // handshake
  assign in_stall = flush_r | fifo_full;
  assign in_fire  = in_valid & ~in_stall;
  assign flush_go = flush_r & ~fifo_full;
  assign push     = (in_fire & row_pending_r) | flush_go;

  // row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r   <= '0;
      row_held_r    <= '0;
      row_pending_r <= 1'b0;
      flush_r       <= 1'b0;
    end else if (flush_go) begin
      row_above_r <= '0;
      row_held_r  <= '0;
      flush_r     <= 1'b0;
    end else if (in_fire) begin
      row_above_r   <= row_pending_r ? row_held_r : '0;
      row_held_r    <= cur_m;
      row_pending_r <= ~in_data.last_row;
      flush_r       <= in_data.last_row;
    end
  end

  // lanes: bottom row's own result sees a dead row below
  assign up_pad   = {1'b0, row_above_r & mask, 1'b0};
  assign mid_pad  = {1'b0, row_held_r & mask, 1'b0};
  assign down_pad = flush_r ? '0 : {1'b0, cur_m, 1'b0};

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    lgrs_lane u_lane (
      .up         (up_pad[l*LANE_COLS +: LANE_COLS+2]),
      .mid        (mid_pad[l*LANE_COLS +: LANE_COLS+2]),
      .down       (down_pad[l*LANE_COLS +: LANE_COLS+2]),
      .next_cells (lane_out[l*LANE_COLS +: LANE_COLS])
    );
  end

  // merge
  assign push_item.next_cells = lane_out & mask;
  assign push_item.is_last    = flush_r;

  lgrs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  a_last_flush : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_row |=> flush_r && !row_pending_r)
    else $error("bottom row did not start its own result");

  a_flush_clear : assert property (@(posedge clk) disable iff (!rst_n)
    flush_go |=> !flush_r && row_held_r == '0 && row_above_r == '0)
    else $error("grid state not cleared after bottom row");

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_full |-> !push)
    else $error("result pushed into full buffer");

endmodule

`default_nettype wire
